// ----- rtl/sqwm_pkg.sv -----
// Shared widths, types and pipeline constants of the scaled quaternion
// world matrix block. No dependencies.
package sqwm_pkg;

  localparam int unsigned NLANE = 9;   // matrix entries, row-major
  localparam int unsigned PW    = 32;  // quaternion products
  localparam int unsigned NW    = 35;  // rotation numerators, signed
  localparam int unsigned NRM_W = 34;  // squared norm, unsigned
  localparam int unsigned MW    = 51;  // scaled numerators and dividend
  localparam int unsigned DW    = 35;  // divisor, twice the norm
  localparam int unsigned QW    = 17;  // quotient, at most 32768

  localparam logic [QW-1:0] QMAX_NEG = QW'(32768);
  localparam logic [QW-1:0] QMAX_POS = QW'(32767);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [NLANE-1:0]   neg;
  } side_t;

endpackage

// ----- rtl/scaled_quaternion_world_matrix.sv -----
// Scaled quaternion world matrix, top level: front pipeline, divider
// pipeline and output saturation. Depends on sqwm_pkg, sqwm_front, sqwm_div.
//
// A request is taken on every cycle that start is high; busy stays low, and
// the receiver cannot hold results off, so nothing inside ever stalls.
// Each request yields one result, shown for one cycle with strobe_o, after
// five stages of products, sums, scale multiply, sign split and dividend
// build, seventeen divider stages (one quotient bit each), and the output
// register. Results appear in request order. Entries are scale * R / |q|^2
// rounded half away from zero and saturated to Q8.8; an all-zero quaternion
// gives the identity rotation. The position passes through unchanged.
module scaled_quaternion_world_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] scale_x_i,
  input  logic signed [15:0] scale_y_i,
  input  logic signed [15:0] scale_z_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               strobe_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m13_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o,
  output logic signed [15:0] m23_o,
  output logic signed [15:0] m31_o,
  output logic signed [15:0] m32_o,
  output logic signed [15:0] m33_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o
);

  localparam int unsigned NL = sqwm_pkg::NLANE;
  localparam int unsigned QW = sqwm_pkg::QW;

  logic                      f_valid, d_valid;
  logic [sqwm_pkg::MW-1:0]   f_numer [NL];
  logic [sqwm_pkg::DW-1:0]   f_denom;
  sqwm_pkg::side_t           f_side, d_side;
  logic [QW-1:0]             d_quot [NL];

  logic                      strobe_q;
  logic signed [15:0]        m_q [NL];
  logic signed [31:0]        px_q, py_q, pz_q;

  assign busy = 1'b0;

  sqwm_front u_front (
    .clk_i, .rst_ni,
    .valid_i   (start && !busy),
    .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .scale_x_i, .scale_y_i, .scale_z_i,
    .pos_x_i, .pos_y_i, .pos_z_i,
    .valid_o   (f_valid),
    .numer_o   (f_numer),
    .denom_o   (f_denom),
    .side_o    (f_side)
  );

  sqwm_div u_div (
    .clk_i, .rst_ni,
    .valid_i   (f_valid),
    .numer_i   (f_numer),
    .denom_i   (f_denom),
    .side_i    (f_side),
    .valid_o   (d_valid),
    .quot_o    (d_quot),
    .side_o    (d_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= d_valid;
    end
  end

  // apply sign and clamp to Q8.8
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NL; l++) begin
      if (d_side.neg[l]) begin
        m_q[l] <= (d_quot[l] > sqwm_pkg::QMAX_NEG) ? -16'sd32768 : 16'(-d_quot[l]);
      end else begin
        m_q[l] <= (d_quot[l] > sqwm_pkg::QMAX_POS) ? 16'sd32767 : 16'(d_quot[l]);
      end
    end
    px_q <= d_side.pos_x;
    py_q <= d_side.pos_y;
    pz_q <= d_side.pos_z;
  end

  assign strobe_o    = strobe_q;
  assign m11_o       = m_q[0];
  assign m12_o       = m_q[1];
  assign m13_o       = m_q[2];
  assign m21_o       = m_q[3];
  assign m22_o       = m_q[4];
  assign m23_o       = m_q[5];
  assign m31_o       = m_q[6];
  assign m32_o       = m_q[7];
  assign m33_o       = m_q[8];
  assign out_pos_x_o = px_q;
  assign out_pos_y_o = py_q;
  assign out_pos_z_o = pz_q;

endmodule

// ----- rtl/sqwm_front.sv -----
// Front pipeline: quaternion products, rotation numerators and norm,
// scale multiply, sign split and dividend build. Depends on sqwm_pkg.
module sqwm_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [15:0]                 quat_x_i,
  input  logic signed [15:0]                 quat_y_i,
  input  logic signed [15:0]                 quat_z_i,
  input  logic signed [15:0]                 quat_w_i,
  input  logic signed [15:0]                 scale_x_i,
  input  logic signed [15:0]                 scale_y_i,
  input  logic signed [15:0]                 scale_z_i,
  input  logic signed [31:0]                 pos_x_i,
  input  logic signed [31:0]                 pos_y_i,
  input  logic signed [31:0]                 pos_z_i,
  output logic                               valid_o,
  output logic [sqwm_pkg::MW-1:0]            numer_o [sqwm_pkg::NLANE],
  output logic [sqwm_pkg::DW-1:0]            denom_o,
  output sqwm_pkg::side_t                    side_o
);

  localparam int unsigned NL = sqwm_pkg::NLANE;
  localparam int unsigned NW = sqwm_pkg::NW;
  localparam int unsigned MW = sqwm_pkg::MW;

  // stage 1: products
  logic                              v1_q;
  logic signed [sqwm_pkg::PW-1:0]    xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  logic signed [15:0]                sc1_q [3];
  sqwm_pkg::side_t                   s1_q, s2_q, s3_q, s4_q;
  logic signed [15:0]                w_eff;

  // stage 2: numerators and norm
  logic                              v2_q;
  logic signed [NW-1:0]              num2_q [NL];
  logic [sqwm_pkg::NRM_W-1:0]        n2_q, n3_q, n4_q;
  logic signed [15:0]                sc2_q [3];

  // stage 3 and 4
  logic                              v3_q, v4_q, v5_q;
  logic signed [MW-1:0]              prod3_q [NL];
  logic [MW-1:0]                     mag4_q [NL];

  function automatic logic signed [NW-1:0] sx(input logic signed [sqwm_pkg::PW-1:0] a);
    sx = {{(NW - sqwm_pkg::PW){a[sqwm_pkg::PW-1]}}, a};
  endfunction

  // zero quaternion is treated as identity
  assign w_eff = (quat_x_i == 16'sd0 && quat_y_i == 16'sd0 && quat_z_i == 16'sd0 &&
                  quat_w_i == 16'sd0) ? 16'sd1 : quat_w_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    ww_q <= w_eff * w_eff;
    xy_q <= quat_x_i * quat_y_i;
    xz_q <= quat_x_i * quat_z_i;
    yz_q <= quat_y_i * quat_z_i;
    xw_q <= quat_x_i * w_eff;
    yw_q <= quat_y_i * w_eff;
    zw_q <= quat_z_i * w_eff;
    sc1_q[0] <= scale_x_i;
    sc1_q[1] <= scale_y_i;
    sc1_q[2] <= scale_z_i;
    s1_q.pos_x <= pos_x_i;
    s1_q.pos_y <= pos_y_i;
    s1_q.pos_z <= pos_z_i;
    s1_q.neg   <= '0;
  end

  logic signed [NW-1:0] nsum;
  assign nsum = sx(xx_q) + sx(yy_q) + sx(zz_q) + sx(ww_q);

  always_ff @(posedge clk_i) begin
    num2_q[0] <= sx(xx_q) + sx(ww_q) - sx(yy_q) - sx(zz_q);
    num2_q[1] <= (sx(xy_q) + sx(zw_q)) <<< 1;
    num2_q[2] <= (sx(xz_q) - sx(yw_q)) <<< 1;
    num2_q[3] <= (sx(xy_q) - sx(zw_q)) <<< 1;
    num2_q[4] <= sx(yy_q) + sx(ww_q) - sx(xx_q) - sx(zz_q);
    num2_q[5] <= (sx(yz_q) + sx(xw_q)) <<< 1;
    num2_q[6] <= (sx(xz_q) + sx(yw_q)) <<< 1;
    num2_q[7] <= (sx(yz_q) - sx(xw_q)) <<< 1;
    num2_q[8] <= sx(zz_q) + sx(ww_q) - sx(xx_q) - sx(yy_q);
    n2_q      <= nsum[sqwm_pkg::NRM_W-1:0];
    sc2_q     <= sc1_q;
    s2_q      <= s1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NL; l++) begin
      prod3_q[l] <= $signed({{(MW - 16){sc2_q[l / 3][15]}}, sc2_q[l / 3]}) *
                    $signed({{(MW - NW){num2_q[l][NW-1]}}, num2_q[l]});
    end
    n3_q <= n2_q;
    s3_q <= s2_q;
  end

  // split sign and magnitude
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NL; l++) begin
      mag4_q[l]     <= prod3_q[l][MW-1] ? MW'(-prod3_q[l]) : MW'(prod3_q[l]);
      s4_q.neg[l]   <= prod3_q[l][MW-1];
    end
    s4_q.pos_x <= s3_q.pos_x;
    s4_q.pos_y <= s3_q.pos_y;
    s4_q.pos_z <= s3_q.pos_z;
    n4_q       <= n3_q;
  end

  // dividend 2*mag + n, divisor 2*n gives round half away from zero
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NL; l++) begin
      numer_o[l] <= {mag4_q[l][MW-2:0], 1'b0} + MW'(n4_q);
    end
    denom_o <= {n4_q, 1'b0};
    side_o  <= s4_q;
  end

  assign valid_o = v5_q;

endmodule

// ----- rtl/sqwm_div.sv -----
// Restoring divider pipeline, one quotient bit per stage for nine lanes
// sharing one divisor. Depends on sqwm_pkg.
module sqwm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [sqwm_pkg::MW-1:0]    numer_i [sqwm_pkg::NLANE],
  input  logic [sqwm_pkg::DW-1:0]    denom_i,
  input  sqwm_pkg::side_t            side_i,
  output logic                       valid_o,
  output logic [sqwm_pkg::QW-1:0]    quot_o [sqwm_pkg::NLANE],
  output sqwm_pkg::side_t            side_o
);

  localparam int unsigned NL = sqwm_pkg::NLANE;
  localparam int unsigned MW = sqwm_pkg::MW;
  localparam int unsigned DW = sqwm_pkg::DW;
  localparam int unsigned QW = sqwm_pkg::QW;

  logic [QW-1:0]         v_q;
  logic [MW-1:0]         rem_q  [QW][NL];
  logic [QW-1:0]         quo_q  [QW][NL];
  logic [DW-1:0]         den_q  [QW];
  sqwm_pkg::side_t       side_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned K = QW - 1 - s;
    logic [MW-1:0]  rem_in [NL];
    logic [QW-1:0]  quo_in [NL];
    logic [DW-1:0]  den_in;
    logic [MW-1:0]  dsh;

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          rem_in[l] = numer_i[l];
          quo_in[l] = '0;
        end
      end
      assign den_in = denom_i;
      always_ff @(posedge clk_i) side_q[s] <= side_i;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          rem_in[l] = rem_q[s-1][l];
          quo_in[l] = quo_q[s-1][l];
        end
      end
      assign den_in = den_q[s-1];
      always_ff @(posedge clk_i) side_q[s] <= side_q[s-1];
    end

    assign dsh = {{(MW - DW){1'b0}}, den_in} << K;

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_in;
      for (int l = 0; l < NL; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_q[s][l] <= rem_in[l] - dsh;
          quo_q[s][l] <= {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_q[s][l] <= rem_in[l];
          quo_q[s][l] <= {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

`ifndef SYNTHESIS
  a_rem_lane0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QW-1] |-> (rem_q[QW-1][0] < {{(MW - DW){1'b0}}, den_q[QW-1]}))
    else $error("lane 0 remainder not below divisor");
  a_rem_lane4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QW-1] |-> (rem_q[QW-1][4] < {{(MW - DW){1'b0}}, den_q[QW-1]}))
    else $error("lane 4 remainder not below divisor");
  a_qbound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[QW-1] && quo_q[QW-1][1][QW-1]) |-> (quo_q[QW-1][1][QW-2:0] == '0))
    else $error("quotient above full scale");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for scaled_quaternion_world_matrix: directed table
// followed by random requests, checked against an in-bench predictor.
// Depends on the RTL top level only.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [15:0] sx, sy, sz;
    logic signed [31:0] px, py, pz;
  } xform_req_t;

  typedef struct {
    logic signed [15:0] m [9];
    logic signed [31:0] px, py, pz;
  } world_mat_t;

  typedef struct {
    xform_req_t req;
    logic       known;
    logic signed [15:0] m [9];
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic signed [15:0] scale_x_i = '0, scale_y_i = '0, scale_z_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic strobe_o;
  logic signed [15:0] m11_o, m12_o, m13_o, m21_o, m22_o, m23_o, m31_o, m32_o, m33_o;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;

  world_mat_t pending_mats [$];
  int  fails = 0;
  longint cycle_cnt = 0;

  always #6 clk_i = ~clk_i;

  scaled_quaternion_world_matrix dut (.*);

  // round(scale*num/n), ties away from zero, clamp to Q8.8
  function automatic logic signed [15:0] scaled_ratio(longint s, longint num, longint n);
    longint prod, mag, q;
    prod = s * num;
    mag = (prod < 0) ? -prod : prod;
    q = (2 * mag + n) / (2 * n);
    if (prod < 0) return (q > 32768) ? -16'sd32768 : 16'(-q);
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  function automatic world_mat_t predict_world_mat(xform_req_t r);
    world_mat_t o;
    longint x, y, z, w, n;
    x = r.qx; y = r.qy; z = r.qz; w = r.qw;
    if (x == 0 && y == 0 && z == 0 && w == 0) w = 1;
    n = x*x + y*y + z*z + w*w;
    o.m[0] = scaled_ratio(r.sx, x*x + w*w - y*y - z*z, n);
    o.m[1] = scaled_ratio(r.sx, 2*(x*y + z*w), n);
    o.m[2] = scaled_ratio(r.sx, 2*(x*z - y*w), n);
    o.m[3] = scaled_ratio(r.sy, 2*(x*y - z*w), n);
    o.m[4] = scaled_ratio(r.sy, y*y + w*w - x*x - z*z, n);
    o.m[5] = scaled_ratio(r.sy, 2*(y*z + x*w), n);
    o.m[6] = scaled_ratio(r.sz, 2*(x*z + y*w), n);
    o.m[7] = scaled_ratio(r.sz, 2*(y*z - x*w), n);
    o.m[8] = scaled_ratio(r.sz, z*z + w*w - x*x - y*y, n);
    o.px = r.px; o.py = r.py; o.pz = r.pz;
    return o;
  endfunction

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'sd0;
      2: return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic xform_req_t rand_req();
    xform_req_t r;
    r.qx = rand_quat(); r.qy = rand_quat(); r.qz = rand_quat(); r.qw = rand_quat();
    r.sx = 16'($urandom); r.sy = 16'($urandom); r.sz = 16'($urandom);
    if ($urandom_range(0, 3) == 0) r.sx = ($urandom_range(0, 1)) ? 16'sh8000 : 16'sh7fff;
    r.px = $urandom; r.py = $urandom; r.pz = $urandom;
    return r;
  endfunction

  task automatic send_request(xform_req_t r);
    start <= 1'b1;
    quat_x_i <= r.qx; quat_y_i <= r.qy; quat_z_i <= r.qz; quat_w_i <= r.qw;
    scale_x_i <= r.sx; scale_y_i <= r.sy; scale_z_i <= r.sz;
    pos_x_i <= r.px; pos_y_i <= r.py; pos_z_i <= r.pz;
    do @(posedge clk_i); while (busy);
    pending_mats.push_back(predict_world_mat(r));
  endtask

  task automatic pause_cycles(int k);
    if (k > 0) begin
      start <= 1'b0;
      repeat (k) @(posedge clk_i);
    end
  endtask

  function automatic dir_row_t mk_row(logic signed [15:0] qx, qy, qz, qw, sx, sy, sz,
                                      logic known, logic signed [15:0] d0, d4, d8);
    dir_row_t t;
    t.req = '{qx, qy, qz, qw, sx, sy, sz, 32'sh7fffffff, 32'sh80000000, 32'h12345678};
    t.known = known;
    t.m = '{d0, 0, 0, 0, d4, 0, 0, 0, d8};
    return t;
  endfunction

  // check results as they come out
  always @(posedge clk_i) begin
    world_mat_t e;
    logic signed [15:0] got [9];
    if (rst_ni && strobe_o) begin
      got = '{m11_o, m12_o, m13_o, m21_o, m22_o, m23_o, m31_o, m32_o, m33_o};
      if (pending_mats.size() == 0) begin
        $display("%0t: unexpected result", $time);
        fails++;
      end else begin
        e = pending_mats.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== e.m[i]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, i/3+1, i%3+1,
                     e.m[i], got[i]);
            fails++;
          end
        if (out_pos_x_o !== e.px || out_pos_y_o !== e.py || out_pos_z_o !== e.pz) begin
          $display("%0t: pos expected %h %h %h actual %h %h %h", $time, e.px, e.py, e.pz,
                   out_pos_x_o, out_pos_y_o, out_pos_z_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 200000) begin
      $display("scaled_quaternion_world_matrix test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    world_mat_t e;
    int drain;
    dir_rows.push_back(mk_row(0, 0, 0, 0, 256, -256, 32767, 1, 256, -256, 32767));
    dir_rows.push_back(mk_row(0, 0, 0, 16384, -32768, 1, 0, 1, -32768, 1, 0));
    dir_rows.push_back(mk_row(0, 0, 0, -16384, 32767, -32768, 256, 1, 32767, -32768, 256));
    // 180 degrees about x: diagonal 1,-1,-1, saturation on -32768 * -1
    dir_rows.push_back(mk_row(16384, 0, 0, 0, 256, -32768, 32767, 1, 256, 32767, -32767));
    dir_rows.push_back(mk_row(0, -16384, 0, 0, -32768, 256, 100, 1, 32767, 256, -100));
    dir_rows.push_back(mk_row(0, 0, 16384, 0, 5, 7, -32768, 1, -5, -7, -32768));
    dir_rows.push_back(mk_row(-32768, 0, 0, 0, 256, 256, 256, 1, 256, -256, -256));
    dir_rows.push_back(mk_row(16384, 16384, 16384, 16384, 256, 256, 256, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(-16384, 16384, -16384, 16384, -32768, 32767, -1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 0, 0, 1, 32767, -32768, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(-1, -1, -1, -1, -32768, -32768, -32768, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(-32768, -32768, -32768, -32768, 3, -3, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(32767, -32768, 11585, -11585, 32767, 32767, 32767, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 1, 0, 1, 1, 1, 0, 0, 0, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        e = predict_world_mat(dir_rows[i].req);
        foreach (e.m[j])
          if ((j % 4 == 0) && e.m[j] !== dir_rows[i].m[j]) begin
            $display("%0t: directed row %0d m%0d%0d expected %0d actual %0d", $time, i,
                     j/3+1, j%3+1, dir_rows[i].m[j], e.m[j]);
            fails++;
          end
      end
      send_request(dir_rows[i].req);
      if (i % 3 == 2) pause_cycles($urandom_range(0, 12));
    end
    pause_cycles(1);
    // hold off until the pipe is empty
    while (pending_mats.size() != 0) @(posedge clk_i);

    for (int i = 0; i < 1300; i++) begin
      send_request(rand_req());
      if ((i / 200) % 2 == 1) pause_cycles($urandom_range(0, 12));
    end
    start <= 1'b0;

    drain = 0;
    while (pending_mats.size() != 0 && drain < 200) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (30) @(posedge clk_i);
    if (fails == 0 && pending_mats.size() == 0)
      $display("scaled_quaternion_world_matrix test passed");
    else
      $display("scaled_quaternion_world_matrix test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sqwm_pkg.sv
rtl/sqwm_front.sv
rtl/sqwm_div.sv
rtl/scaled_quaternion_world_matrix.sv
verif/tb.sv
